### design/sfcrc_pkg.sv
// Shared types, constants and the CRC byte update for the serial frame CRC-16 checker.
package sfcrc_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CRC_POLY       = 3'd0,
    CFG_CRC_INIT       = 3'd1,
    CFG_HEADER_FIRST   = 3'd2,
    CFG_HEADER_SECOND  = 3'd3,
    CFG_CRC_BIG_ENDIAN = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    VERDICT_OK        = 2'd0,
    VERDICT_SHORT     = 2'd1,
    VERDICT_BAD_HDR   = 2'd2,
    VERDICT_BAD_CRC   = 2'd3
  } verdict_e;

  localparam logic [15:0] CrcPolyRst    = 16'h1021;
  localparam logic [15:0] CrcInitRst    = 16'hFFFF;
  localparam logic [7:0]  HeaderFirstRst  = 8'h77;
  localparam logic [7:0]  HeaderSecondRst = 8'hAB;

  typedef struct packed {
    logic [15:0] crc_poly;
    logic [15:0] crc_init;
    logic [7:0]  header_first;
    logic [7:0]  header_second;
    logic        crc_big_endian;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       chunk_end;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  verdict;
    logic [15:0] computed_crc;
  } out_item_t;

  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b,
                                           logic [15:0] poly);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ poly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### design/serial_frame_crc16_checker.sv
// Top level of the serial frame CRC-16 checker: handshakes and result register.
// A byte is registered in the input stage on transfer; its verdict, if any, is then
// registered in the output register when that is free, and out_valid_o rises.
// Throughput: one byte per cycle (single 8-step CRC update per stage) while not stalled.
// A pending result does not block input unless a second result is due.
// Reset: valid flags, frame state and configuration return to defaults; no clearing pass.
module serial_frame_crc16_checker #(
  parameter int unsigned FRAME_BYTES = 128
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sfcrc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [sfcrc_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  sfcrc_pkg::in_item_t            in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output sfcrc_pkg::out_item_t           out_data_o
);
  import sfcrc_pkg::*;

  cfg_t      cfg;
  logic      stage_valid, res_valid, advance, load;
  out_item_t res;

  logic      out_valid_q, out_valid_d;
  out_item_t out_q;

  sfcrc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  sfcrc_frame_check #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .load_i        (load),
    .in_data_i     (in_data_i),
    .advance_i     (advance),
    .stage_valid_o (stage_valid),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  assign advance    = stage_valid && (!res_valid || !out_valid_q || out_ready_i);
  assign in_ready_o = !stage_valid || advance;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance && res_valid) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_ready_when_out_empty : assert property (
    @(posedge clk_i) disable iff (!rst_ni) !out_valid_o |-> in_ready_o
  ) else $error("input stalled with empty result register");

  a_short_crc_zero : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.verdict == VERDICT_SHORT |-> out_data_o.computed_crc == '0
  ) else $error("short chunk reported nonzero CRC");

  a_blocked_result_held : assert property (
    @(posedge clk_i) disable iff (!rst_ni) res_valid && !advance |=> res_valid
  ) else $error("blocked result dropped from input stage");

endmodule

### design/sfcrc_cfg_regs.sv
// Configuration register file of the serial frame CRC-16 checker.
module sfcrc_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sfcrc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [sfcrc_pkg::CfgDataW-1:0] cfg_wdata_i,
  output sfcrc_pkg::cfg_t                cfg_o
);
  import sfcrc_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CRC_POLY:       cfg_d.crc_poly       = cfg_wdata_i;
        CFG_CRC_INIT:       cfg_d.crc_init       = cfg_wdata_i;
        CFG_HEADER_FIRST:   cfg_d.header_first   = cfg_wdata_i[7:0];
        CFG_HEADER_SECOND:  cfg_d.header_second  = cfg_wdata_i[7:0];
        CFG_CRC_BIG_ENDIAN: cfg_d.crc_big_endian = cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.crc_poly       <= CrcPolyRst;
      cfg_q.crc_init       <= CrcInitRst;
      cfg_q.header_first   <= HeaderFirstRst;
      cfg_q.header_second  <= HeaderSecondRst;
      cfg_q.crc_big_endian <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### design/sfcrc_frame_check.sv
// Input stage, frame tracking state, CRC update and verdict logic.
module sfcrc_frame_check #(
  parameter int unsigned FRAME_BYTES = 128
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sfcrc_pkg::cfg_t       cfg_i,
  input  logic                  load_i,
  input  sfcrc_pkg::in_item_t   in_data_i,
  input  logic                  advance_i,
  output logic                  stage_valid_o,
  output logic                  res_valid_o,
  output sfcrc_pkg::out_item_t  res_o
);
  import sfcrc_pkg::*;

  localparam int unsigned PosW = $clog2(FRAME_BYTES + 1);
  localparam logic [PosW-1:0] PosFull = PosW'(FRAME_BYTES);
  localparam logic [PosW-1:0] PosTail = PosW'(FRAME_BYTES - 2);
  localparam logic [PosW-1:0] PosOne  = PosW'(1);

  logic        stage_valid_q, stage_valid_d;
  in_item_t    stage_q;

  logic [PosW-1:0] pos_q, pos_d, pos_n;
  logic [15:0]     crc_q, crc_d, crc_n;
  logic            hdr_q, hdr_d, hdr_n;
  logic [15:0]     rx_q, rx_d, rx_n;
  logic [15:0]     crc_base, crc_upd, rx_cmp;
  logic [7:0]      b;

  assign b        = stage_q.data_byte;
  assign crc_base = (pos_q == '0) ? cfg_i.crc_init : crc_q;
  assign crc_upd  = crc_byte(crc_base, b, cfg_i.crc_poly);

  always_comb begin
    pos_n = pos_q;
    crc_n = crc_q;
    hdr_n = hdr_q;
    rx_n  = rx_q;
    if (pos_q < PosFull) begin
      if (pos_q == '0) begin
        hdr_n = (b == cfg_i.header_first);
        crc_n = crc_upd;
      end else if (pos_q < PosTail) begin
        if (pos_q == PosOne && b != cfg_i.header_second) begin
          hdr_n = 1'b0;
        end
        crc_n = crc_upd;
      end else begin
        rx_n = {rx_q[7:0], b};
      end
      pos_n = pos_q + PosOne;
    end
  end

  assign rx_cmp = cfg_i.crc_big_endian ? rx_n : {rx_n[7:0], rx_n[15:8]};

  always_comb begin
    res_o.computed_crc = crc_n;
    priority if (pos_n < PosFull) begin
      res_o.verdict      = VERDICT_SHORT;
      res_o.computed_crc = '0;
    end else if (!hdr_n) begin
      res_o.verdict = VERDICT_BAD_HDR;
    end else if (rx_cmp != crc_n) begin
      res_o.verdict = VERDICT_BAD_CRC;
    end else begin
      res_o.verdict = VERDICT_OK;
    end
  end

  always_comb begin
    pos_d = pos_q;
    crc_d = crc_q;
    hdr_d = hdr_q;
    rx_d  = rx_q;
    if (stage_valid_q && advance_i) begin
      if (stage_q.chunk_end) begin
        pos_d = '0;
        crc_d = cfg_i.crc_init;
        hdr_d = 1'b1;
        rx_d  = '0;
      end else begin
        pos_d = pos_n;
        crc_d = crc_n;
        hdr_d = hdr_n;
        rx_d  = rx_n;
      end
    end
  end

  always_comb begin
    stage_valid_d = stage_valid_q;
    if (load_i) begin
      stage_valid_d = 1'b1;
    end else if (advance_i) begin
      stage_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
      pos_q         <= '0;
      crc_q         <= CrcInitRst;
      hdr_q         <= 1'b1;
      rx_q          <= '0;
    end else begin
      stage_valid_q <= stage_valid_d;
      pos_q         <= pos_d;
      crc_q         <= crc_d;
      hdr_q         <= hdr_d;
      rx_q          <= rx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      stage_q <= in_data_i;
    end
  end

  assign stage_valid_o = stage_valid_q;
  assign res_valid_o   = stage_valid_q && stage_q.chunk_end;

endmodule
